// ----- sv/gli_pkg.sv -----
`timescale 1ns / 1ps
// Package: types, codes and the read termination check of the bus listener.
package gli_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT_DAV,
		PH_WAIT_REL,
		PH_SETTLE
	} phase_t;

	localparam logic [2:0] RSN_RUNNING  = 3'd0;
	localparam logic [2:0] RSN_EOI      = 3'd1;
	localparam logic [2:0] RSN_TERM     = 3'd2;
	localparam logic [2:0] RSN_DAV_TMO  = 3'd3;
	localparam logic [2:0] RSN_REL_TMO  = 3'd4;
	localparam logic [2:0] RSN_ATN      = 3'd5;
	localparam logic [2:0] RSN_UNLISTEN = 3'd6;

	localparam logic [2:0] TERM_CRLF    = 3'd0;
	localparam logic [2:0] TERM_CR      = 3'd1;
	localparam logic [2:0] TERM_LF      = 3'd2;
	localparam logic [2:0] TERM_NONE    = 3'd3;
	localparam logic [2:0] TERM_LFCR    = 3'd4;
	localparam logic [2:0] TERM_ETX     = 3'd5;
	localparam logic [2:0] TERM_CRLFETX = 3'd6;
	localparam logic [2:0] TERM_EOI     = 3'd7;

	localparam logic [2:0] REG_TERM_MODE   = 3'd0;
	localparam logic [2:0] REG_EOI_EN      = 3'd1;
	localparam logic [2:0] REG_END_BYTE_EN = 3'd2;
	localparam logic [2:0] REG_END_BYTE    = 3'd3;
	localparam logic [2:0] REG_TIMEOUT     = 3'd4;
	localparam logic [2:0] REG_SETTLE      = 3'd5;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_LF  = 8'b0000_1010;
	localparam logic [7:0] CH_CR  = 8'b0000_1101;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1200;

	typedef struct packed {
		logic [2:0]  terminator_mode;
		logic        eoi_enable;
		logic        end_byte_enable;
		logic [7:0]  end_byte;
		logic [15:0] read_timeout;
		logic [7:0]  settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic       listen;
		logic       atn_asserted;
		logic       dav_asserted;
		logic       eoi_asserted;
		logic [7:0] bus_byte;
	} item_t;

	typedef struct packed {
		logic        nrfd_assert;
		logic        ndac_assert;
		logic        byte_valid;
		logic [7:0]  data_byte;
		logic        last;
		logic [2:0]  end_reason;
		logic [15:0] byte_count;
	} result_t;

	// End reason for a delivered byte; b1 and b2 are the two bytes before it.
	function automatic logic [2:0] end_check(cfg_t cfg, logic eoi, logic [7:0] b0,
			logic [7:0] b1, logic [7:0] b2);
		logic hit;
		hit = 1'b0;
		if (cfg.eoi_enable || cfg.terminator_mode == TERM_EOI) begin
			return eoi ? RSN_EOI : RSN_RUNNING;
		end
		if (cfg.end_byte_enable) begin
			hit = (b0 == cfg.end_byte);
		end else begin
			unique case (cfg.terminator_mode)
				TERM_CR:      hit = (b0 == CH_CR);
				TERM_LF:      hit = (b0 == CH_LF);
				TERM_NONE:    hit = 1'b0;
				TERM_LFCR:    hit = (b0 == CH_CR) && (b1 == CH_LF);
				TERM_ETX:     hit = (b0 == CH_ETX);
				TERM_CRLFETX: hit = (b0 == CH_ETX) && (b1 == CH_LF) && (b2 == CH_CR);
				default:      hit = (b0 == CH_LF) && (b1 == CH_CR);
			endcase
		end
		return hit ? RSN_TERM : RSN_RUNNING;
	endfunction

endpackage

// ----- sv/gli_if.sv -----
`timescale 1ns / 1ps
// Interfaces: the sampled bus line channel and the result channel.
interface gli_in_if;
	logic       valid;
	logic       ready;
	logic       listen;
	logic       atn_asserted;
	logic       dav_asserted;
	logic       eoi_asserted;
	logic [7:0] bus_byte;

	modport source (output valid, listen, atn_asserted, dav_asserted, eoi_asserted,
		bus_byte, input ready);
	modport sink (input valid, listen, atn_asserted, dav_asserted, eoi_asserted,
		bus_byte, output ready);
endinterface

interface gli_out_if;
	logic        valid;
	logic        ready;
	logic        nrfd_assert;
	logic        ndac_assert;
	logic        byte_valid;
	logic [7:0]  data_byte;
	logic        last;
	logic [2:0]  end_reason;
	logic [15:0] byte_count;

	modport source (output valid, nrfd_assert, ndac_assert, byte_valid, data_byte, last,
		end_reason, byte_count, input ready);
	modport sink (input valid, nrfd_assert, ndac_assert, byte_valid, data_byte, last,
		end_reason, byte_count, output ready);
endinterface

// ----- sv/gli_core.sv -----
`timescale 1ns / 1ps
// Acceptor handshake state and the per-item step logic with read termination.
module gli_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  gli_pkg::item_t   item,
	input  gli_pkg::cfg_t    cfg,
	output gli_pkg::result_t res
);
	import gli_pkg::*;

	phase_t      phase_q, phase_d, cur_phase;
	logic [15:0] wait_q, wait_d, cur_wait, wait_inc, limit;
	logic [7:0]  settle_q, settle_d, cur_settle, settle_dec;
	logic [7:0]  recent0_q, recent0_d, cur_recent0;
	logic [7:0]  recent1_q, recent1_d, cur_recent1;
	logic [7:0]  latch_byte_q, latch_byte_d;
	logic        latch_eoi_q, latch_eoi_d;
	logic [15:0] count_q, count_d, cur_count;
	logic        listen_prev_q;
	logic        start, tmo, ended, valid;
	logic [2:0]  reason;
	logic [7:0]  data;

	assign start = item.listen && !listen_prev_q;

	always_comb begin
		cur_phase   = start ? PH_WAIT_DAV : phase_q;
		cur_wait    = start ? 16'd0 : wait_q;
		cur_settle  = start ? 8'd0 : settle_q;
		cur_recent0 = start ? 8'd0 : recent0_q;
		cur_recent1 = start ? 8'd0 : recent1_q;
		cur_count   = start ? 16'd0 : count_q;

		wait_inc   = (cur_wait != 16'hFFFF) ? cur_wait + 16'd1 : cur_wait;
		limit      = (cfg.read_timeout != 16'd0) ? cfg.read_timeout : 16'd1;
		settle_dec = (cur_settle != 8'd0) ? cur_settle - 8'd1 : 8'd0;

		phase_d      = cur_phase;
		wait_d       = cur_wait;
		settle_d     = cur_settle;
		recent0_d    = cur_recent0;
		recent1_d    = cur_recent1;
		latch_byte_d = latch_byte_q;
		latch_eoi_d  = latch_eoi_q;
		count_d      = cur_count;
		tmo          = 1'b0;
		ended        = 1'b0;
		valid        = 1'b0;
		reason       = RSN_RUNNING;
		data         = 8'd0;

		if (cur_phase != PH_IDLE) begin
			if (!item.listen) begin
				reason = RSN_UNLISTEN;
				ended  = 1'b1;
			end else if (item.atn_asserted) begin
				reason = RSN_ATN;
				ended  = 1'b1;
			end else if (!start) begin
				unique case (cur_phase)
					PH_WAIT_DAV: begin
						if (item.dav_asserted) begin
							latch_byte_d = item.bus_byte;
							latch_eoi_d  = item.eoi_asserted;
							phase_d      = PH_WAIT_REL;
							wait_d       = 16'd0;
						end else begin
							wait_d = wait_inc;
							if (wait_inc >= limit) begin
								reason = RSN_DAV_TMO;
								ended  = 1'b1;
							end
						end
					end
					PH_WAIT_REL: begin
						if (item.dav_asserted) begin
							wait_d = wait_inc;
							tmo    = (wait_inc >= limit);
						end
						if (!item.dav_asserted || tmo) begin
							valid = 1'b1;
							data  = latch_byte_q;
							if (cur_count != 16'hFFFF) begin
								count_d = cur_count + 16'd1;
							end
							reason = end_check(cfg, latch_eoi_q, latch_byte_q,
								cur_recent0, cur_recent1);
							if (reason == RSN_RUNNING && tmo) begin
								reason = RSN_REL_TMO;
							end
							if (reason != RSN_RUNNING) begin
								ended = 1'b1;
							end else begin
								recent1_d = cur_recent0;
								recent0_d = latch_byte_q;
								wait_d    = 16'd0;
								if (cfg.settle_ticks != 8'd0) begin
									phase_d  = PH_SETTLE;
									settle_d = cfg.settle_ticks;
								end else begin
									phase_d = PH_WAIT_DAV;
								end
							end
						end
					end
					default: begin
						settle_d = settle_dec;
						if (settle_dec == 8'd0) begin
							phase_d = PH_WAIT_DAV;
							wait_d  = 16'd0;
						end
					end
				endcase
			end
			if (ended) begin
				phase_d = PH_IDLE;
			end
		end

		res.nrfd_assert = (phase_d == PH_WAIT_REL) || (phase_d == PH_SETTLE);
		res.ndac_assert = (phase_d == PH_WAIT_DAV) || (phase_d == PH_SETTLE);
		res.byte_valid  = valid;
		res.data_byte   = data;
		res.last        = ended;
		res.end_reason  = ended ? reason : RSN_RUNNING;
		res.byte_count  = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			wait_q        <= 16'd0;
			settle_q      <= 8'd0;
			recent0_q     <= 8'd0;
			recent1_q     <= 8'd0;
			latch_byte_q  <= 8'd0;
			latch_eoi_q   <= 1'b0;
			count_q       <= 16'd0;
			listen_prev_q <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			wait_q        <= wait_d;
			settle_q      <= settle_d;
			recent0_q     <= recent0_d;
			recent1_q     <= recent1_d;
			latch_byte_q  <= latch_byte_d;
			latch_eoi_q   <= latch_eoi_d;
			count_q       <= count_d;
			listen_prev_q <= item.listen;
		end
	end

	// A byte is only ever delivered out of the wait for DAV release.
	a_byte_from_release: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.byte_valid |-> phase_q == PH_WAIT_REL && !start)
		else $error("byte delivered outside the release wait");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.last |=> phase_q == PH_IDLE)
		else $error("read ended but the handshake did not return to idle");

	a_idle_needs_edge: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE && !start |=> phase_q == PH_IDLE)
		else $error("read started without a rising edge of listen");

	a_count_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.byte_valid |-> res.byte_count != 16'd0)
		else $error("byte delivered with a zero byte count");

endmodule

// ----- sv/gpib_listener_receive_with_terminator_unit.sv -----
`timescale 1ns / 1ps
// Bus listener: acceptor handshake with read termination, top level.
//
// Each item on in_ch is one sample of the bus lines (listen, ATN, DAV, EOI and
// the data byte). For every item one result leaves on out_ch: the NRFD and NDAC
// drive after that sample, an optional received byte, the end-of-read flag with
// its reason and the byte count of the current read.
// An accepted item sits in the input register, is processed by the core into
// the result register and is offered on out_ch from there. One item is accepted
// every cycle while the result side keeps taking; the handshake step sets that
// rate. When out_ch stalls, the result register holds and the input register
// still takes one more item; after that in_ch.ready falls until the result is
// taken. Reset clears the handshake to idle, both lines released, the count to
// zero and the registers to their defaults (read timeout 1200, all else zero).
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// keep writes to idle, and the block itself has no check for it.
module gpib_listener_receive_with_terminator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	gli_in_if.sink                       in_ch,
	gli_out_if.source                    out_ch,
	input  logic                         cfg_we,
	input  logic [gli_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [gli_pkg::CfgDataW-1:0] cfg_data
);
	import gli_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t core_res, res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.terminator_mode <= TERM_CRLF;
			cfg_q.eoi_enable      <= 1'b0;
			cfg_q.end_byte_enable <= 1'b0;
			cfg_q.end_byte        <= 8'd0;
			cfg_q.read_timeout    <= TIMEOUT_RESET;
			cfg_q.settle_ticks    <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TERM_MODE:   cfg_q.terminator_mode <= cfg_data[2:0];
				REG_EOI_EN:      cfg_q.eoi_enable      <= cfg_data[0];
				REG_END_BYTE_EN: cfg_q.end_byte_enable <= cfg_data[0];
				REG_END_BYTE:    cfg_q.end_byte        <= cfg_data[7:0];
				REG_TIMEOUT:     cfg_q.read_timeout    <= cfg_data;
				REG_SETTLE:      cfg_q.settle_ticks    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.listen       <= in_ch.listen;
			item_s1.atn_asserted <= in_ch.atn_asserted;
			item_s1.dav_asserted <= in_ch.dav_asserted;
			item_s1.eoi_asserted <= in_ch.eoi_asserted;
			item_s1.bus_byte     <= in_ch.bus_byte;
		end
	end

	gli_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= core_res;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.nrfd_assert = res_s2.nrfd_assert;
	assign out_ch.ndac_assert = res_s2.ndac_assert;
	assign out_ch.byte_valid  = res_s2.byte_valid;
	assign out_ch.data_byte   = res_s2.data_byte;
	assign out_ch.last        = res_s2.last;
	assign out_ch.end_reason  = res_s2.end_reason;
	assign out_ch.byte_count  = res_s2.byte_count;

endmodule

// ----- bench/gpib_listener_receive_with_terminator_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the bus listener: handshake, byte delivery and end of read.
module gpib_listener_receive_with_terminator_unit_test;
	import gli_pkg::*;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_CHECKED,
		ROW_REG
	} row_kind_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_PERIODIC,
		STALL_RANDOM
	} stall_style_t;

	typedef struct packed {
		row_kind_t   kind;
		item_t       smp;
		result_t     want;
		logic [2:0]  reg_idx;
		logic [15:0] reg_val;
	} table_row_t;

	localparam int DIR_ROWS = 25;
	localparam int PHASES   = 10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	gli_in_if  in_ch ();
	gli_out_if out_ch ();

	gpib_listener_receive_with_terminator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Listener state as the bench predicts it.
	cfg_t        rx_cfg;
	phase_t      hs_phase;
	logic [15:0] dav_wait;
	logic [7:0]  settle_left;
	logic [7:0]  last_byte;
	logic [7:0]  older_byte;
	logic [7:0]  held_byte;
	logic        held_eoi;
	logic [15:0] rx_count;
	logic        listen_seen;

	result_t     pending_results [$];
	item_t       line_q [$];
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[gpib_listener_receive_with_terminator_unit] ERROR");
		$finish;
	end

	function automatic logic dav_wait_expired();
		logic [15:0] lim;
		lim = (rx_cfg.read_timeout == 16'd0) ? 16'd1 : rx_cfg.read_timeout;
		if (dav_wait != 16'hFFFF) begin
			dav_wait = dav_wait + 16'd1;
		end
		return dav_wait >= lim;
	endfunction

	// One bus sample in, the line drive and delivery that it causes out.
	function automatic result_t listener_response(item_t s);
		result_t    r;
		logic       starting;
		logic       finished;
		logic       rel_tmo;
		logic       hit;
		logic [2:0] why;
		r = '0;
		finished = 1'b0;
		rel_tmo = 1'b0;
		hit = 1'b0;
		why = RSN_RUNNING;
		starting = s.listen && !listen_seen;
		if (starting) begin
			hs_phase = PH_WAIT_DAV;
			dav_wait = '0;
			settle_left = '0;
			last_byte = '0;
			older_byte = '0;
			rx_count = '0;
		end
		if (hs_phase != PH_IDLE) begin
			if (!s.listen) begin
				why = RSN_UNLISTEN;
				finished = 1'b1;
			end else if (s.atn_asserted) begin
				why = RSN_ATN;
				finished = 1'b1;
			end else if (!starting) begin
				case (hs_phase)
					PH_WAIT_DAV: begin
						if (s.dav_asserted) begin
							held_byte = s.bus_byte;
							held_eoi = s.eoi_asserted;
							hs_phase = PH_WAIT_REL;
							dav_wait = '0;
						end else if (dav_wait_expired()) begin
							why = RSN_DAV_TMO;
							finished = 1'b1;
						end
					end
					PH_WAIT_REL: begin
						if (s.dav_asserted) begin
							rel_tmo = dav_wait_expired();
						end
						if (!s.dav_asserted || rel_tmo) begin
							r.byte_valid = 1'b1;
							r.data_byte = held_byte;
							if (rx_count != 16'hFFFF) begin
								rx_count = rx_count + 16'd1;
							end
							if (rx_cfg.eoi_enable || rx_cfg.terminator_mode == TERM_EOI) begin
								why = held_eoi ? RSN_EOI : RSN_RUNNING;
							end else begin
								if (rx_cfg.end_byte_enable) begin
									hit = (held_byte == rx_cfg.end_byte);
								end else begin
									case (rx_cfg.terminator_mode)
										TERM_CRLF: hit = ({last_byte, held_byte} == {CH_CR, CH_LF});
										TERM_CR: hit = (held_byte == CH_CR);
										TERM_LF: hit = (held_byte == CH_LF);
										TERM_LFCR: hit = ({last_byte, held_byte} == {CH_LF, CH_CR});
										TERM_ETX: hit = (held_byte == CH_ETX);
										TERM_CRLFETX: hit = ({older_byte, last_byte, held_byte} ==
												{CH_CR, CH_LF, CH_ETX});
										default: hit = 1'b0;
									endcase
								end
								why = hit ? RSN_TERM : RSN_RUNNING;
							end
							if (why == RSN_RUNNING && rel_tmo) begin
								why = RSN_REL_TMO;
							end
							if (why != RSN_RUNNING) begin
								finished = 1'b1;
							end else begin
								older_byte = last_byte;
								last_byte = held_byte;
								dav_wait = '0;
								if (rx_cfg.settle_ticks != 8'd0) begin
									hs_phase = PH_SETTLE;
									settle_left = rx_cfg.settle_ticks;
								end else begin
									hs_phase = PH_WAIT_DAV;
								end
							end
						end
					end
					default: begin
						if (settle_left != 8'd0) begin
							settle_left = settle_left - 8'd1;
						end
						if (settle_left == 8'd0) begin
							hs_phase = PH_WAIT_DAV;
							dav_wait = '0;
						end
					end
				endcase
			end
			if (finished) begin
				hs_phase = PH_IDLE;
			end
		end
		listen_seen = s.listen;
		r.nrfd_assert = (hs_phase == PH_WAIT_REL) || (hs_phase == PH_SETTLE);
		r.ndac_assert = (hs_phase == PH_WAIT_DAV) || (hs_phase == PH_SETTLE);
		r.last = finished;
		r.end_reason = finished ? why : RSN_RUNNING;
		r.byte_count = rx_count;
		return r;
	endfunction

	function automatic table_row_t line_row(logic l, logic a, logic d, logic e, logic [7:0] b);
		table_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.smp.listen = l;
		r.smp.atn_asserted = a;
		r.smp.dav_asserted = d;
		r.smp.eoi_asserted = e;
		r.smp.bus_byte = b;
		return r;
	endfunction

	function automatic table_row_t with_result(table_row_t r, logic nrfd, logic ndac, logic bv,
			logic [7:0] db, logic fin, logic [2:0] rsn, logic [15:0] cnt);
		table_row_t o;
		o = r;
		o.kind = ROW_CHECKED;
		o.want.nrfd_assert = nrfd;
		o.want.ndac_assert = ndac;
		o.want.byte_valid = bv;
		o.want.data_byte = db;
		o.want.last = fin;
		o.want.end_reason = rsn;
		o.want.byte_count = cnt;
		return o;
	endfunction

	function automatic table_row_t reg_row(logic [2:0] idx, logic [15:0] val);
		table_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_sample(item_t s, logic typed, result_t want);
		int unsigned gap;
		result_t     model_out;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_ch.listen <= s.listen;
		in_ch.atn_asserted <= s.atn_asserted;
		in_ch.dav_asserted <= s.dav_asserted;
		in_ch.eoi_asserted <= s.eoi_asserted;
		in_ch.bus_byte <= s.bus_byte;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		model_out = listener_response(s);
		pending_results.push_back(typed ? want : model_out);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TERM_MODE: rx_cfg.terminator_mode = val[2:0];
			REG_EOI_EN: rx_cfg.eoi_enable = val[0];
			REG_END_BYTE_EN: rx_cfg.end_byte_enable = val[0];
			REG_END_BYTE: rx_cfg.end_byte = val[7:0];
			REG_TIMEOUT: rx_cfg.read_timeout = val;
			REG_SETTLE: rx_cfg.settle_ticks = val[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// The result side stalls in stretches of changing style.
	initial begin
		int unsigned  span;
		int unsigned  pos;
		int unsigned  period;
		int unsigned  low_part;
		stall_style_t style;
		span = 0;
		pos = 0;
		period = 2;
		low_part = 1;
		style = STALL_NONE;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (pos == span) begin
				pos = 0;
				span = $urandom_range(8, 80);
				style = stall_style_t'($urandom_range(0, 2));
				period = $urandom_range(2, 8);
				low_part = $urandom_range(1, period - 1);
			end
			case (style)
				STALL_NONE: out_ch.ready <= 1'b1;
				STALL_PERIODIC: out_ch.ready <= ((pos % period) >= low_part);
				default: out_ch.ready <= 1'($urandom_range(0, 1));
			endcase
			pos++;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result item arrived with none expected");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("nrfd_assert", 16'(want.nrfd_assert), 16'(out_ch.nrfd_assert));
				compare_field("ndac_assert", 16'(want.ndac_assert), 16'(out_ch.ndac_assert));
				compare_field("byte_valid", 16'(want.byte_valid), 16'(out_ch.byte_valid));
				compare_field("data_byte", 16'(want.data_byte), 16'(out_ch.data_byte));
				compare_field("last", 16'(want.last), 16'(out_ch.last));
				compare_field("end_reason", 16'(want.end_reason), 16'(out_ch.end_reason));
				compare_field("byte_count", want.byte_count, out_ch.byte_count);
			end
		end
	end

	initial begin
		table_row_t  script [DIR_ROWS];
		logic [7:0]  chosen [$];
		item_t       s;
		int unsigned p;
		int unsigned k;
		int unsigned budget;
		int unsigned sent;
		int unsigned lim;
		int unsigned slack;
		int unsigned pre;
		int unsigned hold;
		int unsigned n_bytes;
		logic [2:0]  v_mode;
		logic        v_eoi;
		logic        v_ebe;
		logic [7:0]  v_eb;
		logic [15:0] v_to;
		logic [7:0]  v_st;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.listen = 1'b0;
		in_ch.atn_asserted = 1'b0;
		in_ch.dav_asserted = 1'b0;
		in_ch.eoi_asserted = 1'b0;
		in_ch.bus_byte = '0;

		rx_cfg = '0;
		rx_cfg.read_timeout = TIMEOUT_RESET;
		hs_phase = PH_IDLE;
		dav_wait = '0;
		settle_left = '0;
		last_byte = '0;
		older_byte = '0;
		held_byte = '0;
		held_eoi = 1'b0;
		rx_count = '0;
		listen_seen = 1'b0;

		script = '{
			with_result(line_row(0, 0, 0, 0, 8'h00), 0, 0, 0, 8'h00, 0, RSN_RUNNING, 16'd0),
			// ATN on the very tick that starts the read
			with_result(line_row(1, 1, 0, 0, 8'h00), 0, 0, 0, 8'h00, 1, RSN_ATN, 16'd0),
			// listen still high after the read ended: nothing happens
			with_result(line_row(1, 0, 1, 0, 8'hFF), 0, 0, 0, 8'h00, 0, RSN_RUNNING, 16'd0),
			line_row(0, 0, 0, 0, 8'h00),
			// DAV on the start tick is not sampled
			with_result(line_row(1, 0, 1, 1, 8'hFF), 0, 1, 0, 8'h00, 0, RSN_RUNNING, 16'd0),
			line_row(1, 0, 1, 1, 8'hFF),
			line_row(1, 0, 0, 0, 8'hFF),
			line_row(1, 0, 1, 0, CH_CR),
			line_row(1, 0, 0, 0, CH_CR),
			line_row(1, 0, 1, 0, CH_LF),
			line_row(1, 0, 0, 0, CH_LF),
			line_row(0, 0, 0, 0, 8'h00),
			line_row(1, 0, 0, 0, 8'h00),
			with_result(line_row(1, 1, 0, 0, 8'h00), 0, 0, 0, 8'h00, 1, RSN_ATN, 16'd0),
			line_row(0, 0, 0, 0, 8'h00),
			line_row(1, 0, 0, 0, 8'h00),
			line_row(1, 0, 1, 0, 8'h00),
			// unlisten wins over ATN and drops the latched byte
			with_result(line_row(0, 1, 1, 0, 8'h00), 0, 0, 0, 8'h00, 1, RSN_UNLISTEN, 16'd0),
			reg_row(REG_TIMEOUT, 16'd0),
			with_result(line_row(1, 0, 0, 0, 8'h00), 0, 1, 0, 8'h00, 0, RSN_RUNNING, 16'd0),
			with_result(line_row(1, 0, 0, 0, 8'h00), 0, 0, 0, 8'h00, 1, RSN_DAV_TMO, 16'd0),
			line_row(0, 0, 0, 0, 8'h00),
			line_row(1, 0, 0, 0, 8'h00),
			line_row(1, 0, 1, 1, CH_ETX),
			with_result(line_row(1, 0, 1, 1, CH_ETX), 0, 0, 1, CH_ETX, 1, RSN_REL_TMO, 16'd1)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				drain_results();
				write_register(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_sample(script[i].smp, script[i].kind == ROW_CHECKED, script[i].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				0: begin
					v_mode = TERM_CRLF; v_eoi = 1'b0; v_ebe = 1'b0; v_eb = 8'h00;
					v_to = 16'd6; v_st = 8'd0;
				end
				1: begin
					v_mode = TERM_CR; v_eoi = 1'b0; v_ebe = 1'b0; v_eb = 8'hFF;
					v_to = 16'd1; v_st = 8'd1;
				end
				2: begin
					v_mode = TERM_LF; v_eoi = 1'b0; v_ebe = 1'b1; v_eb = 8'h00;
					v_to = 16'd8; v_st = 8'd2;
				end
				3: begin
					v_mode = TERM_NONE; v_eoi = 1'b1; v_ebe = 1'b0; v_eb = 8'($urandom);
					v_to = 16'hFFFF; v_st = 8'd0;
				end
				4: begin
					v_mode = TERM_LFCR; v_eoi = 1'b0; v_ebe = 1'b0; v_eb = 8'($urandom);
					v_to = 16'd5; v_st = 8'd3;
				end
				5: begin
					v_mode = TERM_ETX; v_eoi = 1'b0; v_ebe = 1'b1; v_eb = 8'hFF;
					v_to = 16'd10; v_st = 8'd0;
				end
				6: begin
					v_mode = TERM_CRLFETX; v_eoi = 1'b0; v_ebe = 1'b0; v_eb = 8'($urandom);
					v_to = 16'd7; v_st = 8'd1;
				end
				7: begin
					v_mode = TERM_EOI; v_eoi = 1'b0; v_ebe = 1'b0; v_eb = 8'($urandom);
					v_to = 16'd4; v_st = 8'd0;
				end
				8: begin
					v_mode = 3'($urandom); v_eoi = 1'($urandom); v_ebe = 1'($urandom);
					v_eb = 8'($urandom); v_to = 16'd3; v_st = 8'd255;
				end
				default: begin
					v_mode = 3'($urandom); v_eoi = 1'($urandom); v_ebe = 1'($urandom);
					v_eb = 8'($urandom); v_to = 16'($urandom_range(1, 12));
					v_st = 8'($urandom_range(0, 3));
				end
			endcase
			write_register(REG_TERM_MODE, 16'(v_mode));
			write_register(REG_EOI_EN, 16'(v_eoi));
			write_register(REG_END_BYTE_EN, 16'(v_ebe));
			write_register(REG_END_BYTE, 16'(v_eb));
			write_register(REG_TIMEOUT, v_to);
			write_register(REG_SETTLE, 16'(v_st));

			// The long settle phase spends hundreds of items on each byte.
			budget = (p == 8) ? 400 : 118;
			line_q.delete();
			for (sent = 0; sent < budget; sent++) begin
				if (line_q.size() == 0) begin
					// Plan one read: a little noise, an unlisten gap, the start and the bytes.
					lim = (rx_cfg.read_timeout == 16'd0) ? 1 : rx_cfg.read_timeout;
					slack = (lim > 3) ? 3 : lim - 1;
					s = '0;
					if ($urandom_range(0, 9) == 0) begin
						repeat ($urandom_range(1, 4)) line_q.push_back(item_t'(12'($urandom)));
					end
					s.bus_byte = 8'($urandom);
					repeat ($urandom_range(1, 2)) line_q.push_back(s);
					s.listen = 1'b1;
					line_q.push_back(s);
					chosen.delete();
					n_bytes = $urandom_range(1, 8);
					while (chosen.size() < n_bytes) begin
						case ($urandom_range(0, 11))
							0: chosen.push_back(CH_CR);
							1: chosen.push_back(CH_LF);
							2: chosen.push_back(CH_ETX);
							3: chosen.push_back(rx_cfg.end_byte);
							4: chosen.push_back(8'h00);
							5: chosen.push_back(8'hFF);
							6: begin
								chosen.push_back(CH_CR);
								chosen.push_back(CH_LF);
							end
							7: begin
								chosen.push_back(CH_LF);
								chosen.push_back(CH_CR);
							end
							8: begin
								chosen.push_back(CH_CR);
								chosen.push_back(CH_LF);
								chosen.push_back(CH_ETX);
							end
							default: chosen.push_back(8'($urandom));
						endcase
					end
					for (k = 0; k < chosen.size(); k++) begin
						// After a delivery the releasing tick and the settle come first.
						pre = $urandom_range(0, slack);
						if (k != 0) begin
							pre += 1 + rx_cfg.settle_ticks;
						end
						hold = 1 + $urandom_range(0, slack);
						if (lim <= 16 && $urandom_range(0, 19) == 0) begin
							pre += lim;
						end
						if (lim <= 16 && $urandom_range(0, 19) == 0) begin
							hold = lim + 1;
						end
						s.dav_asserted = 1'b0;
						s.eoi_asserted = 1'b0;
						repeat (pre) begin
							s.bus_byte = 8'($urandom);
							line_q.push_back(s);
						end
						s.dav_asserted = 1'b1;
						s.bus_byte = chosen[k];
						if (k == chosen.size() - 1) begin
							s.eoi_asserted = ($urandom_range(0, 3) != 0);
						end else begin
							s.eoi_asserted = ($urandom_range(0, 7) == 0);
						end
						repeat (hold) line_q.push_back(s);
						if ($urandom_range(0, 39) == 0) begin
							s.atn_asserted = 1'b1;
							line_q.push_back(s);
							break;
						end
						if ($urandom_range(0, 39) == 0) begin
							s.listen = 1'b0;
							line_q.push_back(s);
							break;
						end
					end
					s.dav_asserted = 1'b0;
					line_q.push_back(s);
				end
				send_sample(line_q.pop_front(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (6) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[gpib_listener_receive_with_terminator_unit] OK");
		end else begin
			$display("[gpib_listener_receive_with_terminator_unit] ERROR");
		end
		$finish;
	end

endmodule
